@@ rtl/arrp_pkg.sv @@
// ============================================================================
// arrp_pkg
// Shared types, character codes and helpers for the range reply parser.
// ============================================================================
package arrp_pkg;

  // Fraction digits accepted after the decimal point of a distance
  localparam int unsigned MAX_FRACTION_DIGITS = 3;

  // Character codes
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_UNIT  = 8'h6D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Scan phase of the byte stream
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_FRAME,
    PH_ANSWERED
  } scan_phase_t;

  // Header letter of the current frame
  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_D,
    HDR_E
  } header_t;

  // One received byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } byte_item_t;

  // One parse result
  typedef struct packed {
    logic        distance_valid;
    logic        error_reported;
    logic [31:0] distance_millimetres;
    logic [15:0] device_error_code;
  } reply_result_t;

  // Scale factor that turns a fraction of n digits into thousandths
  function automatic logic [9:0] fraction_scale(input logic [1:0] n);
    logic [9:0] s;
    begin
      case (n)
        2'd1:    s = 10'd100;
        2'd2:    s = 10'd10;
        2'd3:    s = 10'd1;
        default: s = 10'd0;
      endcase
      return s;
    end
  endfunction

endpackage

@@ rtl/ascii_range_reply_parser_unit.sv @@
// ============================================================================
// ascii_range_reply_parser_unit
// Parser for the ASCII reply of a laser range sensor, one byte per cycle unless stalled.
// ============================================================================
// Takes one reply byte per transaction and looks for the first good frame,
// "D=<metres>[.<fraction>]m...<CR><LF>" or "E=<code><CR><LF>". The byte that
// carries end_of_buffer yields one result transaction: distance in millimetres
// (modulo 2^32) or a device error code (modulo 2^16), or all zeros when no
// good frame was seen; the parser then returns to its reset state. The block
// accepts one byte every cycle unless held back as described below. A byte
// is held in an input register and folded into the parse state as it leaves
// that register; an end_of_buffer byte loads its result into the output
// register at the same update. The rate rests on a full update of the parse
// state per byte (a multiply-add by ten per digit, and whole metres times
// 1000 at frame close). Bytes are held back only while a finished result
// waits in the output register and another end_of_buffer byte is ready.
// ============================================================================
module ascii_range_reply_parser_unit #(
  parameter int unsigned MAX_FRACTION_DIGITS = arrp_pkg::MAX_FRACTION_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  arrp_pkg::byte_item_t    byte_item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output arrp_pkg::reply_result_t result
);

  // Input register
  logic                 item_valid;
  arrp_pkg::byte_item_t item;
  logic                 accept;
  logic                 fire;

  // Parse state
  arrp_pkg::scan_phase_t phase,  phase_next;
  arrp_pkg::header_t     header, header_next;
  logic        cr_pending,      cr_pending_next;
  logic [31:0] whole_metres,    whole_metres_next;
  logic [9:0]  thousandths,     thousandths_next;
  logic [1:0]  frac_count,      frac_count_next;
  logic        dot_seen,        dot_seen_next;
  logic        unit_seen,       unit_seen_next;
  logic        frame_good,      frame_good_next;
  logic [15:0] code_acc,        code_acc_next;
  logic        answer_found,    answer_found_next;
  logic        answer_is_error, answer_is_error_next;
  logic [31:0] answer_distance, answer_distance_next;
  logic [15:0] answer_code,     answer_code_next;

  // Byte decode
  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit;
  logic        good_eff;
  logic [9:0]  frac_scaled;
  arrp_pkg::reply_result_t result_next;

  assign c        = item.rx_byte;
  assign is_digit = (c >= arrp_pkg::CHAR_ZERO) && (c <= arrp_pkg::CHAR_NINE);
  assign digit    = 4'(c - arrp_pkg::CHAR_ZERO);
  // A lone CR fails the frame unless the unit was already seen
  assign good_eff = cr_pending ? (frame_good & unit_seen) : frame_good;
  assign frac_scaled = 10'(thousandths * arrp_pkg::fraction_scale(frac_count));

  // Process the held byte unless it would produce a result that has no room
  assign fire = item_valid &
                (~item.end_of_buffer | ~result_valid | ~result_stall);
  assign byte_stall = item_valid & ~fire;
  assign accept     = byte_valid & ~byte_stall;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept | (item_valid & ~fire);
    end
    if (accept) begin
      item <= byte_item;
    end
  end

  // Advance the parse state by one byte
  always_comb begin
    phase_next           = phase;
    header_next          = header;
    cr_pending_next      = cr_pending;
    whole_metres_next    = whole_metres;
    thousandths_next     = thousandths;
    frac_count_next      = frac_count;
    dot_seen_next        = dot_seen;
    unit_seen_next       = unit_seen;
    frame_good_next      = frame_good;
    code_acc_next        = code_acc;
    answer_found_next    = answer_found;
    answer_is_error_next = answer_is_error;
    answer_distance_next = answer_distance;
    answer_code_next     = answer_code;

    unique case (phase)
      arrp_pkg::PH_SEARCH: begin
        if (header != arrp_pkg::HDR_NONE && c == arrp_pkg::CHAR_EQ) begin
          cr_pending_next   = 1'b0;
          whole_metres_next = '0;
          thousandths_next  = '0;
          frac_count_next   = '0;
          dot_seen_next     = 1'b0;
          unit_seen_next    = 1'b0;
          frame_good_next   = 1'b1;
          code_acc_next     = '0;
          phase_next        = arrp_pkg::PH_FRAME;
        end else if (c == arrp_pkg::CHAR_D) begin
          header_next = arrp_pkg::HDR_D;
        end else if (c == arrp_pkg::CHAR_E) begin
          header_next = arrp_pkg::HDR_E;
        end else begin
          header_next = arrp_pkg::HDR_NONE;
        end
      end
      arrp_pkg::PH_FRAME: begin
        if (cr_pending && c == arrp_pkg::CHAR_LF) begin
          // Close the frame and record the answer if it parsed
          if (header == arrp_pkg::HDR_D && frame_good && unit_seen) begin
            answer_found_next    = 1'b1;
            answer_is_error_next = 1'b0;
            answer_distance_next = 32'(whole_metres * 32'd1000) +
                                   32'(frac_scaled);
            answer_code_next     = '0;
            phase_next           = arrp_pkg::PH_ANSWERED;
          end else if (header == arrp_pkg::HDR_E && frame_good) begin
            answer_found_next    = 1'b1;
            answer_is_error_next = 1'b1;
            answer_distance_next = '0;
            answer_code_next     = code_acc;
            phase_next           = arrp_pkg::PH_ANSWERED;
          end else begin
            phase_next = arrp_pkg::PH_SEARCH;
          end
          header_next       = arrp_pkg::HDR_NONE;
          cr_pending_next   = 1'b0;
          whole_metres_next = '0;
          thousandths_next  = '0;
          frac_count_next   = '0;
          dot_seen_next     = 1'b0;
          unit_seen_next    = 1'b0;
          frame_good_next   = 1'b1;
          code_acc_next     = '0;
        end else begin
          frame_good_next = good_eff;
          cr_pending_next = 1'b0;
          if (c == arrp_pkg::CHAR_CR) begin
            cr_pending_next = 1'b1;
          end else if (good_eff && !unit_seen) begin
            // Body byte
            if (header == arrp_pkg::HDR_E) begin
              if (is_digit) begin
                code_acc_next = 16'(code_acc * 16'd10) + 16'(digit);
              end else begin
                frame_good_next = 1'b0;
              end
            end else if (is_digit) begin
              if (!dot_seen) begin
                whole_metres_next = 32'(whole_metres * 32'd10) + 32'(digit);
              end else if (32'(frac_count) < MAX_FRACTION_DIGITS) begin
                thousandths_next = 10'(thousandths * 10'd10) + 10'(digit);
                frac_count_next  = frac_count + 2'd1;
              end else begin
                frame_good_next = 1'b0;
              end
            end else if (c == arrp_pkg::CHAR_DOT) begin
              if (dot_seen) begin
                frame_good_next = 1'b0;
              end else begin
                dot_seen_next = 1'b1;
              end
            end else if (c == arrp_pkg::CHAR_UNIT) begin
              unit_seen_next = 1'b1;
            end else begin
              frame_good_next = 1'b0;
            end
          end
        end
      end
      arrp_pkg::PH_ANSWERED: begin
        phase_next = arrp_pkg::PH_ANSWERED;
      end
      default: begin
        phase_next = arrp_pkg::PH_SEARCH;
      end
    endcase
  end

  // Build the result from the answer after this byte
  always_comb begin
    result_next.distance_valid       = answer_found_next & ~answer_is_error_next;
    result_next.error_reported       = answer_found_next & answer_is_error_next;
    result_next.distance_millimetres = result_next.distance_valid ?
                                       answer_distance_next : '0;
    result_next.device_error_code    = result_next.error_reported ?
                                       answer_code_next : '0;
  end

  // Update the parse state; drop it back to reset after the last byte
  always_ff @(posedge clk) begin
    if (rst || (fire && item.end_of_buffer)) begin
      phase           <= arrp_pkg::PH_SEARCH;
      header          <= arrp_pkg::HDR_NONE;
      cr_pending      <= 1'b0;
      whole_metres    <= '0;
      thousandths     <= '0;
      frac_count      <= '0;
      dot_seen        <= 1'b0;
      unit_seen       <= 1'b0;
      frame_good      <= 1'b1;
      code_acc        <= '0;
      answer_found    <= 1'b0;
      answer_is_error <= 1'b0;
      answer_distance <= '0;
      answer_code     <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      header          <= header_next;
      cr_pending      <= cr_pending_next;
      whole_metres    <= whole_metres_next;
      thousandths     <= thousandths_next;
      frac_count      <= frac_count_next;
      dot_seen        <= dot_seen_next;
      unit_seen       <= unit_seen_next;
      frame_good      <= frame_good_next;
      code_acc        <= code_acc_next;
      answer_found    <= answer_found_next;
      answer_is_error <= answer_is_error_next;
      answer_distance <= answer_distance_next;
      answer_code     <= answer_code_next;
    end
  end

  // Hold the result until its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && item.end_of_buffer) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
    if (fire && item.end_of_buffer) begin
      result <= result_next;
    end
  end

endmodule

@@ tb/sv/ascii_range_reply_parser_unit_tb.sv @@
// ============================================================================
// ascii_range_reply_parser_unit_tb
// Self-checking testbench for the ASCII range reply parser.
// ============================================================================
// Feeds reply buffers byte by byte. A short directed set comes first. Then
// random buffers follow, built mostly from well-formed D and E frames with
// random content, mixed with broken frames, lone CRs, unterminated frames
// and noise. A predictor in the testbench parses the same bytes and queues
// one expected reply per end-of-buffer byte. Each result transaction is
// compared field by field with the oldest queued reply. Both sides idle at
// random. The receiver also holds off once for a long stretch while short
// buffers keep coming, and the sender once waits for every reply to drain.
// ============================================================================
module ascii_range_reply_parser_unit_tb;

  localparam int ITEM_TARGET        = 750;
  localparam int THOUSANDTHS_DIGITS = 3;
  localparam int LONG_HOLD_CYCLES   = 150;
  localparam int BURST_REPLIES      = 12;
  localparam int DRAIN_CYCLES       = 8;
  localparam int CYCLE_LIMIT        = 100000;

  // Parser predictor and the queue of replies it expects
  class reply_predictor;
    arrp_pkg::scan_phase_t   phase;
    arrp_pkg::header_t       letter;
    bit                      cr_pending;
    bit [31:0]               whole;
    bit [9:0]                thou;
    bit [1:0]                frac_digits;
    bit                      dot_seen;
    bit                      unit_seen;
    bit                      frame_good;
    bit [15:0]               code;
    bit                      found;
    bit                      is_err;
    bit [31:0]               ans_dist;
    bit [15:0]               ans_code;
    arrp_pkg::reply_result_t expected_replies[$];
    int                      mismatches;

    function new();
      mismatches = 0;
      reset_parser();
    endfunction

    function void clear_frame();
      cr_pending  = 1'b0;
      whole       = '0;
      thou        = '0;
      frac_digits = '0;
      dot_seen    = 1'b0;
      unit_seen   = 1'b0;
      frame_good  = 1'b1;
      code        = '0;
    endfunction

    function void reset_parser();
      phase    = arrp_pkg::PH_SEARCH;
      letter   = arrp_pkg::HDR_NONE;
      clear_frame();
      found    = 1'b0;
      is_err   = 1'b0;
      ans_dist = '0;
      ans_code = '0;
    endfunction

    // Fold one body byte into the open frame
    function void body_byte(bit [7:0] c);
      bit       is_digit;
      bit [3:0] d;
      is_digit = (c >= arrp_pkg::CHAR_ZERO) && (c <= arrp_pkg::CHAR_NINE);
      d = is_digit ? 4'(c - arrp_pkg::CHAR_ZERO) : 4'd0;
      if (!frame_good || unit_seen) return;
      if (letter == arrp_pkg::HDR_E) begin
        if (is_digit) code = code * 16'd10 + 16'(d);
        else frame_good = 1'b0;
        return;
      end
      if (is_digit) begin
        if (!dot_seen) begin
          whole = whole * 32'd10 + 32'(d);
        end else if (frac_digits < arrp_pkg::MAX_FRACTION_DIGITS) begin
          thou = thou * 10'd10 + 10'(d);
          frac_digits++;
        end else begin
          frame_good = 1'b0;
        end
      end else if (c == arrp_pkg::CHAR_DOT) begin
        if (dot_seen) frame_good = 1'b0;
        else dot_seen = 1'b1;
      end else if (c == arrp_pkg::CHAR_UNIT) begin
        unit_seen = 1'b1;
      end else begin
        frame_good = 1'b0;
      end
    endfunction

    // Advance the parse by one accepted byte; queue a reply on end of buffer
    function void note_byte(arrp_pkg::byte_item_t item);
      bit [7:0]                c;
      bit [31:0]               frac;
      arrp_pkg::reply_result_t r;
      c = item.rx_byte;
      case (phase)
        arrp_pkg::PH_SEARCH: begin
          if (letter != arrp_pkg::HDR_NONE && c == arrp_pkg::CHAR_EQ) begin
            clear_frame();
            phase = arrp_pkg::PH_FRAME;
          end else if (c == arrp_pkg::CHAR_D) begin
            letter = arrp_pkg::HDR_D;
          end else if (c == arrp_pkg::CHAR_E) begin
            letter = arrp_pkg::HDR_E;
          end else begin
            letter = arrp_pkg::HDR_NONE;
          end
        end
        arrp_pkg::PH_FRAME: begin
          if (cr_pending && c == arrp_pkg::CHAR_LF) begin
            // close the frame at CR LF
            if (letter == arrp_pkg::HDR_D && frame_good && unit_seen) begin
              frac = 32'(thou);
              for (int n = frac_digits; n < THOUSANDTHS_DIGITS; n++)
                frac = frac * 32'd10;
              found    = 1'b1;
              is_err   = 1'b0;
              ans_dist = whole * 32'd1000 + frac;
              ans_code = '0;
              phase    = arrp_pkg::PH_ANSWERED;
            end else if (letter == arrp_pkg::HDR_E && frame_good) begin
              found    = 1'b1;
              is_err   = 1'b1;
              ans_dist = '0;
              ans_code = code;
              phase    = arrp_pkg::PH_ANSWERED;
            end else begin
              phase = arrp_pkg::PH_SEARCH;
            end
            letter = arrp_pkg::HDR_NONE;
            clear_frame();
          end else begin
            // a CR not followed by LF counts as a body byte
            if (cr_pending) begin
              cr_pending = 1'b0;
              body_byte(arrp_pkg::CHAR_CR);
            end
            if (c == arrp_pkg::CHAR_CR) cr_pending = 1'b1;
            else body_byte(c);
          end
        end
        default: ;
      endcase
      if (item.end_of_buffer) begin
        r.distance_valid       = found && !is_err;
        r.error_reported       = found && is_err;
        r.distance_millimetres = r.distance_valid ? ans_dist : 32'd0;
        r.device_error_code    = r.error_reported ? ans_code : 16'd0;
        expected_replies.push_back(r);
        reset_parser();
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one result transaction with the oldest expected reply
    task check_reply(arrp_pkg::reply_result_t got);
      arrp_pkg::reply_result_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("result with no reply pending: %h", got));
        return;
      end
      want = expected_replies.pop_front();
      if (got.distance_valid !== want.distance_valid)
        report($sformatf("distance_valid %b, want %b",
                         got.distance_valid, want.distance_valid));
      if (got.error_reported !== want.error_reported)
        report($sformatf("error_reported %b, want %b",
                         got.error_reported, want.error_reported));
      if (got.distance_millimetres !== want.distance_millimetres)
        report($sformatf("distance_millimetres %0d, want %0d",
                         got.distance_millimetres, want.distance_millimetres));
      if (got.device_error_code !== want.device_error_code)
        report($sformatf("device_error_code %0d, want %0d",
                         got.device_error_code, want.device_error_code));
    endtask
  endclass

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    byte_valid   = 1'b0;
  logic                    byte_stall;
  arrp_pkg::byte_item_t    byte_item    = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  arrp_pkg::reply_result_t result;

  reply_predictor sb;
  bit [7:0]       reply_bytes[$];
  bit             calm       = 1'b0;
  bit             hold_req   = 1'b0;
  int             hold_left  = 0;
  int             stall_left = 0;
  int             items_sent = 0;
  int             buffers    = 0;
  int             cycles     = 0;

  ascii_range_reply_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Timeout guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Drive result_stall: long hold on request, else a random wait per result
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req     <= 1'b0;
      hold_left    = LONG_HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Check each accepted result transaction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_reply(result);
      stall_left = calm ? 0 : $urandom_range(0, 8);
    end
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) reply_bytes.push_back(s[i]);
  endfunction

  function automatic void push_digits(int n);
    repeat (n) reply_bytes.push_back(arrp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_noise();
    reply_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_crlf();
    reply_bytes.push_back(arrp_pkg::CHAR_CR);
    reply_bytes.push_back(arrp_pkg::CHAR_LF);
  endfunction

  // Build one random buffer: mostly D and E frames, some broken, some noise
  function automatic void make_reply();
    int kind;
    reply_bytes.delete();
    repeat ($urandom_range(0, 2)) push_noise();
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        push_text("D=");
        push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                : $urandom_range(0, 4));
        if ($urandom_range(0, 2) != 0) begin
          reply_bytes.push_back(arrp_pkg::CHAR_DOT);
          push_digits(($urandom_range(0, 9) == 0) ? 4 : $urandom_range(0, 3));
          // second dot
          if ($urandom_range(0, 15) == 0) begin
            reply_bytes.push_back(arrp_pkg::CHAR_DOT);
            push_digits(1);
          end
        end
        if ($urandom_range(0, 9) == 0) push_noise();
        if ($urandom_range(0, 9) != 0) reply_bytes.push_back(arrp_pkg::CHAR_UNIT);
        // trailing text after the unit, with a lone CR now and then
        repeat ($urandom_range(0, 2)) reply_bytes.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 3) == 0) begin
          reply_bytes.push_back(arrp_pkg::CHAR_CR);
          reply_bytes.push_back(8'($urandom_range(32, 126)));
        end
      end else if (kind <= 7) begin
        push_text("E=");
        push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(5, 8)
                                                : $urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) push_noise();
        if ($urandom_range(0, 7) == 0) begin
          reply_bytes.push_back(arrp_pkg::CHAR_CR);
          push_digits(1);
        end
      end else begin
        repeat ($urandom_range(1, 6)) push_noise();
      end
      // leave a frame open now and then
      if (kind <= 7 && $urandom_range(0, 11) != 0) push_crlf();
    end
  endfunction

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input arrp_pkg::byte_item_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= item;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sb.note_byte(item);
    items_sent++;
    @(negedge clk);
  endtask

  // Send the current buffer, flagging its last byte
  task automatic send_reply();
    arrp_pkg::byte_item_t item;
    for (int i = 0; i < reply_bytes.size(); i++) begin
      item.rx_byte       = reply_bytes[i];
      item.end_of_buffer = (i == reply_bytes.size() - 1);
      send_byte(item);
    end
    buffers++;
  endtask

  // Stop offering until every expected reply has arrived
  task automatic wait_replies_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: lone bytes at both extremes, empty E body, short fraction,
    // one fraction digit too many
    reply_bytes = {8'hFF};
    send_reply();
    reply_bytes = {8'h00};
    send_reply();
    reply_bytes.delete();
    push_text("E=");
    push_crlf();
    send_reply();
    reply_bytes.delete();
    push_text("D=9.5m");
    push_crlf();
    send_reply();
    reply_bytes.delete();
    push_text("D=1.2345m");
    push_crlf();
    send_reply();

    // random buffers
    while (items_sent < ITEM_TARGET) begin
      if (buffers == 15) wait_replies_drained();
      if (buffers == 25) begin
        // long receiver hold while short buffers pile up
        hold_req <= 1'b1;
        calm = 1'b1;
        repeat (BURST_REPLIES) begin
          reply_bytes.delete();
          push_noise();
          send_reply();
        end
      end
      calm = ($urandom_range(0, 5) == 0);
      make_reply();
      send_reply();
    end
    calm = 1'b0;
    byte_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
